[rtl/cts_pkg.sv]
// Shared types and constants for the CBOR token serialiser.
package cts_pkg;

  // Token kinds as carried on req_type
  typedef enum logic [3:0] {
    K_UINT    = 4'd0,
    K_SINT    = 4'd1,
    K_BSTR    = 4'd2,
    K_TSTR    = 4'd3,
    K_ARRAY   = 4'd4,
    K_MAP     = 4'd5,
    K_TAG     = 4'd6,
    K_DOUBLE  = 4'd7,
    K_NULL    = 4'd8,
    K_FALSE   = 4'd9,
    K_TRUE    = 4'd10,
    K_PAYLOAD = 4'd11
  } kind_t;

  // Major types
  localparam logic [2:0] MT_UINT = 3'd0;
  localparam logic [2:0] MT_NINT = 3'd1;

  // Additional-information codes for the argument length
  localparam logic [4:0] AI_IMM_MAX = 5'd23;
  localparam logic [4:0] AI_U8      = 5'd24;
  localparam logic [4:0] AI_U16     = 5'd25;
  localparam logic [4:0] AI_U32     = 5'd26;
  localparam logic [4:0] AI_U64     = 5'd27;

  // Fixed bytes
  localparam logic [7:0] B_HALF    = 8'hf9;
  localparam logic [7:0] B_DOUBLE  = 8'hfb;
  localparam logic [7:0] B_NAN     = 8'h7e;
  localparam logic [7:0] B_POS_INF = 8'h7c;
  localparam logic [7:0] B_NEG_INF = 8'hfc;
  localparam logic [7:0] B_NULL    = 8'hf6;
  localparam logic [7:0] B_FALSE   = 8'hf4;
  localparam logic [7:0] B_TRUE    = 8'hf5;

  localparam logic [10:0] EXP_ALL_ONES = 11'h7ff;

  // Bytes per token: 1 to 9
  localparam int unsigned NB_W = 4;

  // Decoded token: head byte, body bytes left-aligned, total byte count
  typedef struct packed {
    logic [7:0]      head;
    logic [63:0]     body;
    logic [NB_W-1:0] nbytes;
  } tok_t;

  // Queue between front and back
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

endpackage

[rtl/cts_if.sv]
// Channel interfaces: token input and encoded byte output.
interface cts_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  req_type;
  logic [63:0] value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface cts_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, output out_byte, output last_byte, input ready);
  modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

[rtl/cts_front.sv]
// Front end: accepts tokens and decodes each into head byte, body and length.
module cts_front (
  cts_in_if.sink         in_chan,
  output cts_pkg::tok_t  q_tok,
  output logic           q_valid,
  input  logic           q_ready
);
  import cts_pkg::*;

  // Shortest-form head for a major type and a 64-bit argument
  function automatic tok_t head_enc(input logic [2:0] major, input logic [63:0] arg);
    tok_t t;
    t.body = '0;
    if (arg <= 64'(AI_IMM_MAX)) begin
      t.head   = {major, arg[4:0]};
      t.nbytes = NB_W'(1);
    end else if (arg[63:8] == '0) begin
      t.head   = {major, AI_U8};
      t.body   = {arg[7:0], 56'd0};
      t.nbytes = NB_W'(2);
    end else if (arg[63:16] == '0) begin
      t.head   = {major, AI_U16};
      t.body   = {arg[15:0], 48'd0};
      t.nbytes = NB_W'(3);
    end else if (arg[63:32] == '0) begin
      t.head   = {major, AI_U32};
      t.body   = {arg[31:0], 32'd0};
      t.nbytes = NB_W'(5);
    end else begin
      t.head   = {major, AI_U64};
      t.body   = arg;
      t.nbytes = NB_W'(9);
    end
    return t;
  endfunction

  function automatic tok_t one_byte(input logic [7:0] b);
    tok_t t;
    t.head   = b;
    t.body   = '0;
    t.nbytes = NB_W'(1);
    return t;
  endfunction

  function automatic tok_t half_form(input logic [7:0] b1);
    tok_t t;
    t.head   = B_HALF;
    t.body   = {b1, 56'd0};
    t.nbytes = NB_W'(3);
    return t;
  endfunction

  logic [63:0] v;
  logic        known;

  assign v = in_chan.value;

  always_comb begin
    known = 1'b1;
    q_tok = one_byte(v[7:0]);
    unique case (in_chan.req_type) inside
      K_UINT:  q_tok = head_enc(MT_UINT, v);
      K_SINT:  q_tok = v[63] ? head_enc(MT_NINT, ~v) : head_enc(MT_UINT, v);
      K_BSTR, K_TSTR, K_ARRAY, K_MAP, K_TAG:
               q_tok = head_enc(in_chan.req_type[2:0], v);
      K_DOUBLE: begin
        if (v[62:52] == EXP_ALL_ONES) begin
          if (v[51:0] != '0) q_tok = half_form(B_NAN);
          else               q_tok = half_form(v[63] ? B_NEG_INF : B_POS_INF);
        end else begin
          q_tok.head   = B_DOUBLE;
          q_tok.body   = v;
          q_tok.nbytes = NB_W'(9);
        end
      end
      K_NULL:    q_tok = one_byte(B_NULL);
      K_FALSE:   q_tok = one_byte(B_FALSE);
      K_TRUE:    q_tok = one_byte(B_TRUE);
      K_PAYLOAD: q_tok = one_byte(v[7:0]);
      default:   known = 1'b0; // undefined kinds are swallowed
    endcase
  end

  assign q_valid       = in_chan.valid && known;
  assign in_chan.ready = q_ready;

endmodule

[rtl/cts_fifo.sv]
// Short token queue between the front and back ends.
module cts_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  cts_pkg::tok_t push_tok,
  input  logic          push_valid,
  output logic          push_ready,
  output cts_pkg::tok_t pop_tok,
  output logic          pop_valid,
  input  logic          pop_ready
);
  import cts_pkg::*;

  tok_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign push_ready = (cnt_r != Q_CNT_W'(Q_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_tok    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_tok;
  end

endmodule

[rtl/cts_back.sv]
// Back end: shifts decoded tokens out one byte per cycle, while out_chan is not stalled, into the output register.
module cts_back (
  input  logic          clk,
  input  logic          rst_n,
  input  cts_pkg::tok_t q_tok,
  input  logic          q_valid,
  output logic          q_ready,
  cts_out_if.source     out_chan
);
  import cts_pkg::*;

  logic [71:0]     sr_r, sr_nxt;     // remaining bytes, next one on top
  logic [NB_W-1:0] cnt_r, cnt_nxt;   // bytes left in sr_r
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_byte_r, out_byte_nxt;
  logic            out_last_r, out_last_nxt;

  logic [71:0]     src;
  logic [NB_W-1:0] scnt;
  logic            busy, adv, emit;

  assign busy = (cnt_r != '0);
  assign adv  = !out_valid_r || out_chan.ready;

  // Mid-token bytes come from the shift register, a new token straight
  // from the queue head so single-byte tokens flow every cycle while out_chan takes them.
  always_comb begin
    src  = busy ? sr_r : {q_tok.head, q_tok.body};
    scnt = busy ? cnt_r : (q_valid ? q_tok.nbytes : '0);
  end

  assign emit    = adv && (scnt != '0);
  assign q_ready = adv && !busy;

  always_comb begin
    sr_nxt        = sr_r;
    cnt_nxt       = cnt_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    if (emit) begin
      out_byte_nxt  = src[71:64];
      out_last_nxt  = (scnt == NB_W'(1));
      sr_nxt        = {src[63:0], 8'd0};
      cnt_nxt       = scnt - NB_W'(1);
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sr_r       <= sr_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.out_byte  = out_byte_r;
  assign out_chan.last_byte = out_last_r;

endmodule

[rtl/cbor_token_serializer_top.sv]
// Top level of the CBOR token serialiser: front end, token queue, back end.
//
//  channel   dir  payload              handshake
//  in_chan   in   req_type[3:0],       valid/ready, item taken when both high
//                 value[63:0]
//  out_chan  out  out_byte[7:0],       valid/ready, item taken when both high
//                 last_byte
//
// A token of n encoded bytes (1, 2, 3, 5 or 9) is shifted out of the back-end
// shift register one byte at a time; single-byte tokens (payload, null, bools,
// small heads) stream at one item per cycle while out_chan is not stalled.
// The front end decodes in the accepting cycle and writes a 2-entry queue;
// in_chan stalls only while that queue is full, behind a multi-byte token
// or a stalled out_chan.
// Undefined token kinds (12 to 15) are accepted and produce no bytes.
// Reset (rst_n low, synchronous) empties the queue and drops out_chan.valid.
// out_chan is driven straight from registers; a stall holds the byte.
module cbor_token_serializer_top (
  input  logic       clk,
  input  logic       rst_n,
  cts_in_if.sink     in_chan,
  cts_out_if.source  out_chan
);
  import cts_pkg::*;

  tok_t front_tok;   // decoded token into the queue
  logic front_valid;
  logic front_ready;
  tok_t back_tok;    // queue head to the back end
  logic back_valid;
  logic back_ready;

  cts_front u_front (
    .in_chan (in_chan),
    .q_tok   (front_tok),
    .q_valid (front_valid),
    .q_ready (front_ready)
  );

  cts_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_tok   (front_tok),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_tok    (back_tok),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready)
  );

  cts_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_tok    (back_tok),
    .q_valid  (back_valid),
    .q_ready  (back_ready),
    .out_chan (out_chan)
  );

endmodule

[rtl/cts_checker.sv]
// Port-level checks for the CBOR token serialiser, bound to the top level.
module cts_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       last_byte
);
  import cts_pkg::*;

  // Next accepted byte opens a new token
  logic at_start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_start_r <= 1'b1;
    end else if (out_valid && out_ready) begin
      at_start_r <= last_byte;
    end
  end

  // Nothing is offered in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // A stalled byte holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_byte) && $stable(last_byte)))
    else $error("stalled output byte changed");

  // A token's bytes come without gaps
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !last_byte) |=> out_valid)
    else $error("gap inside an encoded token");

  // Half-precision marker as a token's first byte is followed by a special-value byte
  a_half_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && at_start_r && !last_byte && out_byte == B_HALF) |=>
      (out_valid && !last_byte &&
       (out_byte == B_NAN || out_byte == B_POS_INF || out_byte == B_NEG_INF)))
    else $error("bad byte after half-precision marker");

endmodule

bind cbor_token_serializer_top cts_checker u_cts_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_byte  (out_chan.out_byte),
  .last_byte (out_chan.last_byte)
);
